@@ rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the symbol lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PAD   = 8'h3D;

  typedef enum logic [2:0] {
    KIND_DATA       = 3'd0,
    KIND_DONE       = 3'd1,
    KIND_BAD_SYMBOL = 3'd2,
    KIND_BAD_PAD    = 3'd3,
    KIND_BAD_END    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_mode_t;

  // One front-end decision: up to three data bytes, then an optional closing result
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  n_data;
    logic        has_end;
    kind_t       end_kind;
  } burst_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/b64d_in_if.sv @@
// ----------------------------------------------------------------------------
// b64d_in_if
// Character channel: one text byte and an end-of-message flag per transfer.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       msg_last;

  modport source (output valid, output in_char, output msg_last, input ready);
  modport sink   (input valid, input in_char, input msg_last, output ready);
endinterface

@@ rtl/b64d_out_if.sv @@
// ----------------------------------------------------------------------------
// b64d_out_if
// Result channel: decoded byte or status, with a last-of-item flag.
// ----------------------------------------------------------------------------
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic       run_last;

  modport source (output valid, output out_byte, output kind, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input run_last,
                  output ready);
endinterface

@@ rtl/base64_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming base64 text decoder: one character in, data bytes and status out.
// ----------------------------------------------------------------------------
// Path: results go through the burst queue, then the burst and output registers.
// Throughput: one character per cycle while the burst queue has room; results leave
//   one per cycle while the output is ready, so a character that closes a group with
//   the end flag (up to four results) holds input once the four-entry burst queue fills.
// Reset: synchronous, active low; clears group, padding and drop state, empties
//   the queue and drops any pending result.
module base64_decoder (
  input  logic       clk,
  input  logic       rst_n,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);

  logic             q_ready;
  logic             push;
  b64d_pkg::burst_t push_burst;
  logic             pop;
  logic             head_valid;
  b64d_pkg::burst_t head_burst;

  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_burst (push_burst)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_burst (push_burst),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_burst (head_burst)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_burst (head_burst),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, tracks the group and padding state and
// pushes one burst descriptor per character that causes any result.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic              clk,
  input  logic              rst_n,
  b64d_in_if.sink           in_ch,
  input  logic              q_ready,
  output logic              push,
  output b64d_pkg::burst_t  push_burst
);

  logic [17:0]         group_bits_r, group_bits_nxt;
  logic [1:0]          group_pos_r, group_pos_nxt;
  b64d_pkg::pad_mode_t pad_mode_r, pad_mode_nxt;
  logic                dropping_r, dropping_nxt;

  logic            accept;
  logic            is_ws;
  logic            is_pad;
  logic            bad_pad;
  logic            bad_sym;
  logic [5:0]      sym_val;
  b64d_pkg::sym_t  sym;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign sym         = b64d_pkg::sym_lookup(in_ch.in_char);

  always_comb begin
    is_ws   = (in_ch.in_char == b64d_pkg::CH_SPACE) || (in_ch.in_char == b64d_pkg::CH_TAB) ||
              (in_ch.in_char == b64d_pkg::CH_LF)    || (in_ch.in_char == b64d_pkg::CH_CR);
    is_pad  = (in_ch.in_char == b64d_pkg::CH_PAD);
    bad_pad = is_pad && (pad_mode_r == b64d_pkg::PAD_NONE) && (group_pos_r < 2'd2);
    bad_sym = !is_ws && !is_pad && !sym.ok;
    sym_val = is_pad ? 6'd0 : sym.val;

    group_bits_nxt = group_bits_r;
    group_pos_nxt  = group_pos_r;
    pad_mode_nxt   = pad_mode_r;
    dropping_nxt   = dropping_r;
    push           = 1'b0;
    push_burst     = '{bytes: 24'd0, n_data: 2'd0, has_end: 1'b0,
                       end_kind: b64d_pkg::KIND_DONE};

    if (accept) begin
      if (dropping_r) begin
        // discard up to and including the end of the failed message
        if (in_ch.msg_last) begin
          dropping_nxt = 1'b0;
        end
      end else if (bad_pad || bad_sym) begin
        push                = 1'b1;
        push_burst.has_end  = 1'b1;
        push_burst.end_kind = bad_pad ? b64d_pkg::KIND_BAD_PAD : b64d_pkg::KIND_BAD_SYMBOL;
        group_bits_nxt      = 18'd0;
        group_pos_nxt       = 2'd0;
        pad_mode_nxt        = b64d_pkg::PAD_NONE;
        dropping_nxt        = !in_ch.msg_last;
      end else begin
        if (is_pad && (pad_mode_r == b64d_pkg::PAD_NONE)) begin
          pad_mode_nxt = (group_pos_r == 2'd2) ? b64d_pkg::PAD_ONE : b64d_pkg::PAD_TWO;
        end
        if (!is_ws) begin
          if (group_pos_r == 2'd3) begin
            push_burst.bytes = {group_bits_r, sym_val};
            unique case (pad_mode_nxt)
              b64d_pkg::PAD_ONE: push_burst.n_data = 2'd1;
              b64d_pkg::PAD_TWO: push_burst.n_data = 2'd2;
              default:           push_burst.n_data = 2'd3;
            endcase
            group_bits_nxt = 18'd0;
            group_pos_nxt  = 2'd0;
          end else begin
            group_bits_nxt = {group_bits_r[11:0], sym_val};
            group_pos_nxt  = group_pos_r + 2'd1;
          end
        end
        if (in_ch.msg_last) begin
          push_burst.has_end  = 1'b1;
          push_burst.end_kind = (group_pos_nxt == 2'd0) ? b64d_pkg::KIND_DONE
                                                         : b64d_pkg::KIND_BAD_END;
          group_bits_nxt      = 18'd0;
          group_pos_nxt       = 2'd0;
          pad_mode_nxt        = b64d_pkg::PAD_NONE;
        end
        push = (push_burst.n_data != 2'd0) || push_burst.has_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_bits_r <= 18'd0;
      group_pos_r  <= 2'd0;
      pad_mode_r   <= b64d_pkg::PAD_NONE;
      dropping_r   <= 1'b0;
    end else begin
      group_bits_r <= group_bits_nxt;
      group_pos_r  <= group_pos_nxt;
      pad_mode_r   <= pad_mode_nxt;
      dropping_r   <= dropping_nxt;
    end
  end

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    dropping_r |-> !push)
    else $error("result pushed while dropping a failed message");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_burst.n_data != 2'd0) || push_burst.has_end)
    else $error("empty burst pushed");

  a_error_starts_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_burst.has_end && push_burst.n_data == 2'd0 && !in_ch.msg_last &&
     (push_burst.end_kind == b64d_pkg::KIND_BAD_SYMBOL ||
      push_burst.end_kind == b64d_pkg::KIND_BAD_PAD)) |=> dropping_r)
    else $error("error without entering drop mode");

endmodule

@@ rtl/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Short burst queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64d_pkg::burst_t  push_burst,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output b64d_pkg::burst_t  head_burst
);

  localparam logic [b64d_pkg::QAW:0] FULL_CNT = (b64d_pkg::QAW + 1)'(b64d_pkg::QDEPTH);

  b64d_pkg::burst_t          mem_r [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [b64d_pkg::QAW:0]    count_r, count_nxt;
  logic                      do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_burst = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("push into a full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[b64d_pkg::QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Unrolls each burst into single results, one per cycle while the output is
// ready, through a registered output stage.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  b64d_pkg::burst_t  head_burst,
  output logic              pop,
  b64d_out_if.source        out_ch
);

  b64d_pkg::burst_t cur_r;
  logic             busy_r, busy_nxt;
  logic [1:0]       idx_r, idx_nxt;

  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r;
  b64d_pkg::kind_t  ok_r;
  logic             ol_r;

  logic             out_free;
  logic             emit;
  logic             emit_last;
  logic             emit_data;
  logic [2:0]       total;
  logic [7:0]       emit_byte;
  b64d_pkg::kind_t  emit_kind;

  assign out_free  = !ov_r || out_ch.ready;
  assign emit      = busy_r && out_free;
  assign total     = {1'b0, cur_r.n_data} + {2'b00, cur_r.has_end};
  assign emit_data = (idx_r < cur_r.n_data);
  assign emit_last = ({1'b0, idx_r} == (total - 3'd1));
  assign emit_kind = emit_data ? b64d_pkg::KIND_DATA : cur_r.end_kind;
  assign pop       = head_valid && (!busy_r || (emit && emit_last));

  always_comb begin
    case (idx_r)
      2'd0:    emit_byte = cur_r.bytes[23:16];
      2'd1:    emit_byte = cur_r.bytes[15:8];
      default: emit_byte = cur_r.bytes[7:0];
    endcase
    if (!emit_data) begin
      emit_byte = 8'd0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (emit) begin
      if (emit_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    ov_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_burst;
    end
    if (emit) begin
      ob_r <= emit_byte;
      ok_r <= emit_kind;
      ol_r <= emit_last;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.kind     = ok_r;
  assign out_ch.run_last = ol_r;

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ok_r != b64d_pkg::KIND_DATA) |-> ol_r)
    else $error("status result not marked last");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, idx_r} < total))
    else $error("result index past end of burst");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ok_r != b64d_pkg::KIND_DATA) |-> (ob_r == 8'd0))
    else $error("status result carries a non-zero byte");

endmodule
